/* src/rbas_pkg.sv */
`timescale 1ns / 1ps

package rbas_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int COORD_W     = 32;
    localparam int DEPTH_W     = 5;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ACT_ACCUM        = 2'd0,
        ACT_SAVE         = 2'd1,
        ACT_RESTORE      = 2'd2,
        ACT_RESTORE_CLIP = 2'd3
    } action_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
        logic   has_box;
    } box_t;

    typedef struct packed {
        action_e action;
        coord_t  left_edge;
        coord_t  top_edge;
        coord_t  right_edge;
        coord_t  bottom_edge;
    } item_t;

    typedef struct packed {
        box_t    box;
        cnt_t    count;
        status_e status;
        logic    push;
    } step_t;

    typedef struct packed {
        logic wr_en;
        idx_t wr_idx;
        idx_t rd_idx;
    } stack_req_t;

endpackage

/* src/rbas_stack.sv */
`timescale 1ns / 1ps

module rbas_stack #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // contents are not cleared: only entries written by a save are popped
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/rbas_box_step.sv */
`timescale 1ns / 1ps

module rbas_box_step (
    input  rbas_pkg::item_t item,
    input  rbas_pkg::box_t  cur_box,
    input  rbas_pkg::cnt_t  count,
    input  rbas_pkg::box_t  top_box,
    output rbas_pkg::step_t step_next
);
    import rbas_pkg::*;

    function automatic box_t merge_rect(box_t b, coord_t l, coord_t t, coord_t r, coord_t bo);
        box_t res;
        res = b;
        if (l < r && t < bo) begin
            if (!b.has_box) begin
                res.min_x   = l;
                res.min_y   = t;
                res.max_x   = r;
                res.max_y   = bo;
                res.has_box = 1'b1;
            end else begin
                if (l < b.min_x) res.min_x = l;
                if (t < b.min_y) res.min_y = t;
                if (r > b.max_x) res.max_x = r;
                if (bo > b.max_y) res.max_y = bo;
            end
        end
        return res;
    endfunction

    coord_t ll, lt, lr, lb;

    // layer box, intersected with the item's rectangle for restore with clip
    always_comb begin
        ll = cur_box.min_x;
        lt = cur_box.min_y;
        lr = cur_box.max_x;
        lb = cur_box.max_y;
        if (item.action == ACT_RESTORE_CLIP) begin
            if (item.left_edge > ll)   ll = item.left_edge;
            if (item.top_edge > lt)    lt = item.top_edge;
            if (item.right_edge < lr)  lr = item.right_edge;
            if (item.bottom_edge < lb) lb = item.bottom_edge;
        end
    end

    always_comb begin
        step_next.box    = cur_box;
        step_next.count  = count;
        step_next.status = ST_OK;
        step_next.push   = 1'b0;
        unique case (item.action)
            ACT_ACCUM: begin
                step_next.box = merge_rect(cur_box, item.left_edge, item.top_edge,
                                           item.right_edge, item.bottom_edge);
            end
            ACT_SAVE: begin
                if (count >= CNT_W'(STACK_DEPTH)) begin
                    step_next.status = ST_FULL;
                end else begin
                    step_next.push  = 1'b1;
                    step_next.count = count + CNT_W'(1);
                    step_next.box   = '0;
                end
            end
            ACT_RESTORE, ACT_RESTORE_CLIP: begin
                if (count == '0) begin
                    step_next.status = ST_EMPTY;
                end else begin
                    step_next.count = count - CNT_W'(1);
                    if (cur_box.has_box) begin
                        step_next.box = merge_rect(top_box, ll, lt, lr, lb);
                    end else begin
                        step_next.box = top_box;
                    end
                end
            end
            default: begin
                step_next.box = cur_box;
            end
        endcase
    end

endmodule

/* src/rect_bounds_accumulator_stack_core.sv */
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                                  tuser
// s_        in   left_edge, top_edge, right_edge, bottom_edge        action
// m_        out  bound_left/top/right/bottom, depth_now, zero fill   bound_valid, status
//
// one beat per cycle sustained while m_tready holds; each input beat passes the input register,
// then the box and stack update into the result register
// s_tready follows m_tready through the input register when both stages are full
// reset clears the box, the depth and the valid flags; stack entries are not cleared

module rect_bounds_accumulator_stack_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // left_edge, top_edge, right_edge, bottom_edge
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // bound_left, bound_top, bound_right, bound_bottom,
                                    // depth_now, zero fill
    output logic [2:0]   m_tuser    // bound_valid, status
);
    import rbas_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    box_t       cur_box_reg;
    cnt_t       count_reg;
    logic       out_valid_reg;
    box_t       bound_reg;
    logic [DEPTH_W-1:0] depth_reg;
    status_e    status_reg;
    logic       fwd_sel_reg;
    box_t       fwd_box_reg;

    logic       advance;
    item_t      s_item;
    box_t       top_box;
    box_t       ram_box;
    step_t      step_next;
    stack_req_t stack_req;
    cnt_t       count_after;
    cnt_t       top_cnt;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign s_item.action      = action_e'(s_tuser);
    assign s_item.left_edge   = s_tdata[31:0];
    assign s_item.top_edge    = s_tdata[63:32];
    assign s_item.right_edge  = s_tdata[95:64];
    assign s_item.bottom_edge = s_tdata[127:96];

    // the ram read register holds the entry below the next depth, except for an entry just pushed
    assign count_after      = advance ? step_next.count : count_reg;
    assign top_cnt          = count_after - CNT_W'(1);
    assign stack_req.wr_en  = advance && step_next.push;
    assign stack_req.wr_idx = count_reg[IDX_W-1:0];
    assign stack_req.rd_idx = top_cnt[IDX_W-1:0];

    rbas_stack #(
        .WIDTH ($bits(box_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (stack_req.wr_en),
        .wr_addr (stack_req.wr_idx),
        .wr_data (cur_box_reg),
        .rd_addr (stack_req.rd_idx),
        .rd_data (ram_box)
    );

    // a box pushed last cycle is not yet in the read register
    assign top_box = fwd_sel_reg ? fwd_box_reg : ram_box;

    rbas_box_step u_step (
        .item      (in_item_reg),
        .cur_box   (cur_box_reg),
        .count     (count_reg),
        .top_box   (top_box),
        .step_next (step_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_box_reg   <= '0;
            count_reg     <= '0;
            fwd_sel_reg   <= 1'b0;
        end else begin
            fwd_sel_reg <= stack_req.wr_en;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                cur_box_reg   <= step_next.box;
                count_reg     <= step_next.count;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (stack_req.wr_en) begin
            fwd_box_reg <= cur_box_reg;
        end
        if (advance) begin
            bound_reg  <= step_next.box.has_box ? step_next.box : '0;
            depth_reg  <= DEPTH_W'(step_next.count);
            status_reg <= step_next.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, depth_reg, bound_reg.max_y, bound_reg.max_x,
                       bound_reg.min_y, bound_reg.min_x};
    assign m_tuser  = {status_reg, bound_reg.has_box};

`ifndef SYNTHESIS
    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_full_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg == ST_FULL) |-> depth_reg == DEPTH_W'(STACK_DEPTH))
        else $error("full status with stack not full");

    a_empty_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg == ST_EMPTY) |-> depth_reg == '0)
        else $error("empty status with stack not empty");

    a_empty_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !bound_reg.has_box) |-> m_tdata[127:0] == '0)
        else $error("empty box reports nonzero bounds");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        stack_req.wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push without depth increment");
`endif

endmodule
